@@ design/srt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and constants for the status register transfer unit.
// ----------------------------------------------------------------------------
package srt_pkg;

    localparam logic [31:0] STATUS_RESET = 32'h0000_00D3;
    localparam int          BANK_DEPTH   = 5;
    localparam int          BANK_IDX_W   = $clog2(BANK_DEPTH);

    typedef logic [BANK_IDX_W-1:0] t_bank_idx;

    localparam logic [4:0] MODE_USR = 5'b10000;
    localparam logic [4:0] MODE_FIQ = 5'b10001;
    localparam logic [4:0] MODE_IRQ = 5'b10010;
    localparam logic [4:0] MODE_SVC = 5'b10011;
    localparam logic [4:0] MODE_ABT = 5'b10111;
    localparam logic [4:0] MODE_UND = 5'b11011;
    localparam logic [4:0] MODE_SYS = 5'b11111;

    localparam t_bank_idx BANK_FIQ = t_bank_idx'(0);
    localparam t_bank_idx BANK_IRQ = t_bank_idx'(1);
    localparam t_bank_idx BANK_SVC = t_bank_idx'(2);
    localparam t_bank_idx BANK_ABT = t_bank_idx'(3);
    localparam t_bank_idx BANK_UND = t_bank_idx'(4);

    typedef enum logic [1:0] {
        CMD_REG_TO_SR = 2'd0,
        CMD_IMM_TO_SR = 2'd1,
        CMD_SR_TO_REG = 2'd2,
        CMD_NONE      = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        COND_EQ = 4'd0,
        COND_NE = 4'd1,
        COND_CS = 4'd2,
        COND_CC = 4'd3,
        COND_MI = 4'd4,
        COND_PL = 4'd5,
        COND_VS = 4'd6,
        COND_VC = 4'd7,
        COND_HI = 4'd8,
        COND_LS = 4'd9,
        COND_GE = 4'd10,
        COND_LT = 4'd11,
        COND_GT = 4'd12,
        COND_LE = 4'd13,
        COND_AL = 4'd14,
        COND_NV = 4'd15
    } t_cond;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] instr;
        logic [31:0] source_value;
    } t_item;

    typedef struct packed {
        logic        en;
        logic        to_bank;
        t_bank_idx   idx;
        logic [31:0] data;
    } t_sf_wr;

    typedef struct packed {
        logic        executed;
        logic        reg_write;
        logic [3:0]  dest_index;
        logic [31:0] dest_value;
        logic [31:0] status_out;
    } t_result;

endpackage
`default_nettype wire

@@ design/srt_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srt_in_if
// Instruction transfer channel: valid/ready with instruction payload.
// ----------------------------------------------------------------------------
interface srt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] instr;
    logic [31:0] source_value;

    modport source (output valid, output cmd, output instr, output source_value,
                    input ready);
    modport sink   (input valid, input cmd, input instr, input source_value,
                    output ready);
endinterface
`default_nettype wire

@@ design/srt_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srt_out_if
// Result transfer channel: valid/ready with result payload.
// ----------------------------------------------------------------------------
interface srt_out_if;
    logic        valid;
    logic        ready;
    logic        executed;
    logic        reg_write;
    logic [3:0]  dest_index;
    logic [31:0] dest_value;
    logic [31:0] status_out;

    modport source (output valid, output executed, output reg_write,
                    output dest_index, output dest_value, output status_out,
                    input ready);
    modport sink   (input valid, input executed, input reg_write,
                    input dest_index, input dest_value, input status_out,
                    output ready);
endinterface
`default_nettype wire

@@ design/status_register_transfer_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// status_register_transfer_unit
// Status word transfer unit: input register, execute logic, result register.
// ----------------------------------------------------------------------------
// Path: input transfer to result valid passes the input register, then the
//   result register; the status file updates as the result loads.
// Throughput: one instruction per cycle while the result side does not stall;
//   the execute path between the input and result registers is combinational.
// Reset: synchronous active-low; status word to 0x000000D3, saved words to 0.
module status_register_transfer_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    srt_in_if.sink      i_in,
    srt_out_if.source   o_out
);

    logic               r_in_valid;
    srt_pkg::t_item     r_in;
    logic               r_out_valid;
    srt_pkg::t_result   r_res;

    logic               advance;
    srt_pkg::t_sf_wr    sf_wr;
    srt_pkg::t_bank_idx bank_ridx;
    srt_pkg::t_result   n_res;
    logic [31:0]        cur_status;
    logic [31:0]        bank_rdata;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.cmd          <= i_in.cmd;
            r_in.instr        <= i_in.instr;
            r_in.source_value <= i_in.source_value;
        end
    end

    srt_exec u_exec (
        .i_fire       (advance),
        .i_item       (r_in),
        .i_cur_status (cur_status),
        .i_bank_rdata (bank_rdata),
        .o_bank_ridx  (bank_ridx),
        .o_wr         (sf_wr),
        .o_result     (n_res)
    );

    srt_status_file u_status_file (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (sf_wr),
        .i_bank_ridx  (bank_ridx),
        .o_cur_status (cur_status),
        .o_bank_rdata (bank_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.executed   = r_res.executed;
    assign o_out.reg_write  = r_res.reg_write;
    assign o_out.dest_index = r_res.dest_index;
    assign o_out.dest_value = r_res.dest_value;
    assign o_out.status_out = r_res.status_out;

`ifndef SYNTH
    a_write_needs_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.reg_write |-> r_res.executed)
        else $error("register write without execution");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.reg_write |-> r_res.dest_value == 32'd0
                                            && r_res.dest_index == 4'd0)
        else $error("destination fields set without register write");

    a_status_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_res.status_out == cur_status)
        else $error("reported status differs from status register");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(cur_status))
        else $error("status word changed without an advance");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in))
        else $error("stalled instruction dropped or changed");
`endif

endmodule
`default_nettype wire

@@ design/srt_status_file.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srt_status_file
// Current status word and the five mode-banked saved status words.
// ----------------------------------------------------------------------------
module srt_status_file (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire srt_pkg::t_sf_wr   i_wr,
    input  wire srt_pkg::t_bank_idx i_bank_ridx,
    output logic [31:0]            o_cur_status,
    output logic [31:0]            o_bank_rdata
);

    logic [31:0] r_cur;
    logic [31:0] r_bank [srt_pkg::BANK_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= srt_pkg::STATUS_RESET;
            for (int i = 0; i < srt_pkg::BANK_DEPTH; i++) begin
                r_bank[i] <= '0;
            end
        end else if (i_wr.en) begin
            if (i_wr.to_bank) begin
                r_bank[i_wr.idx] <= i_wr.data;
            end else begin
                r_cur <= i_wr.data;
            end
        end
    end

    assign o_cur_status = r_cur;
    assign o_bank_rdata = (i_bank_ridx < srt_pkg::t_bank_idx'(srt_pkg::BANK_DEPTH))
                          ? r_bank[i_bank_ridx] : '0;

endmodule
`default_nettype wire

@@ design/srt_exec.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srt_exec
// Condition test, status word selection, immediate rotate and result build.
// ----------------------------------------------------------------------------
module srt_exec (
    input  wire logic               i_fire,
    input  wire srt_pkg::t_item     i_item,
    input  wire logic [31:0]        i_cur_status,
    input  wire logic [31:0]        i_bank_rdata,
    output srt_pkg::t_bank_idx      o_bank_ridx,
    output srt_pkg::t_sf_wr         o_wr,
    output srt_pkg::t_result        o_result
);

    logic        n_flag, z_flag, c_flag, v_flag;
    logic        cond_ok;
    logic        sel_ok;
    logic        sel_bank;
    logic        executed;
    logic        is_read;
    logic [4:0]  rot_amt;
    logic [63:0] imm_dbl;
    logic [63:0] imm_shr;
    logic [31:0] wdata;
    srt_pkg::t_cmd  cmd;
    srt_pkg::t_bank_idx sel_idx;

    assign n_flag = i_cur_status[31];
    assign z_flag = i_cur_status[30];
    assign c_flag = i_cur_status[29];
    assign v_flag = i_cur_status[28];
    assign cmd    = srt_pkg::t_cmd'(i_item.cmd);

    always_comb begin
        unique case (srt_pkg::t_cond'(i_item.instr[31:28]))
            srt_pkg::COND_EQ: cond_ok = z_flag;
            srt_pkg::COND_NE: cond_ok = !z_flag;
            srt_pkg::COND_CS: cond_ok = c_flag;
            srt_pkg::COND_CC: cond_ok = !c_flag;
            srt_pkg::COND_MI: cond_ok = n_flag;
            srt_pkg::COND_PL: cond_ok = !n_flag;
            srt_pkg::COND_VS: cond_ok = v_flag;
            srt_pkg::COND_VC: cond_ok = !v_flag;
            srt_pkg::COND_HI: cond_ok = c_flag && !z_flag;
            srt_pkg::COND_LS: cond_ok = !c_flag || z_flag;
            srt_pkg::COND_GE: cond_ok = (n_flag == v_flag);
            srt_pkg::COND_LT: cond_ok = (n_flag != v_flag);
            srt_pkg::COND_GT: cond_ok = !z_flag && (n_flag == v_flag);
            srt_pkg::COND_LE: cond_ok = z_flag || (n_flag != v_flag);
            srt_pkg::COND_AL: cond_ok = 1'b1;
            srt_pkg::COND_NV: cond_ok = 1'b0;
        endcase
    end

    // pick current word or the saved word of the current mode; an unknown mode blocks execution
    always_comb begin
        sel_ok   = 1'b1;
        sel_bank = 1'b0;
        sel_idx  = srt_pkg::BANK_FIQ;
        if (i_item.instr[22]) begin
            unique case (i_cur_status[4:0])
                srt_pkg::MODE_USR,
                srt_pkg::MODE_SYS: sel_bank = 1'b0;
                srt_pkg::MODE_FIQ: begin sel_bank = 1'b1; sel_idx = srt_pkg::BANK_FIQ; end
                srt_pkg::MODE_IRQ: begin sel_bank = 1'b1; sel_idx = srt_pkg::BANK_IRQ; end
                srt_pkg::MODE_SVC: begin sel_bank = 1'b1; sel_idx = srt_pkg::BANK_SVC; end
                srt_pkg::MODE_ABT: begin sel_bank = 1'b1; sel_idx = srt_pkg::BANK_ABT; end
                srt_pkg::MODE_UND: begin sel_bank = 1'b1; sel_idx = srt_pkg::BANK_UND; end
                default:           sel_ok = 1'b0;
            endcase
        end
    end

    assign rot_amt = {i_item.instr[11:8], 1'b0};
    assign imm_dbl = {24'd0, i_item.instr[7:0], 24'd0, i_item.instr[7:0]};
    assign imm_shr = imm_dbl >> rot_amt;
    assign wdata   = (cmd == srt_pkg::CMD_REG_TO_SR) ? i_item.source_value
                                                     : imm_shr[31:0];

    assign executed = (cmd != srt_pkg::CMD_NONE) && cond_ok && sel_ok;
    assign is_read  = (cmd == srt_pkg::CMD_SR_TO_REG);

    assign o_bank_ridx = sel_idx;

    assign o_wr.en      = i_fire && executed && !is_read;
    assign o_wr.to_bank = sel_bank;
    assign o_wr.idx     = sel_idx;
    assign o_wr.data    = wdata;

    assign o_result.executed   = executed;
    assign o_result.reg_write  = executed && is_read;
    assign o_result.dest_index = (executed && is_read) ? i_item.instr[15:12] : 4'd0;
    assign o_result.dest_value = (executed && is_read)
                                 ? (sel_bank ? i_bank_rdata : i_cur_status) : 32'd0;
    assign o_result.status_out = (executed && !is_read && !sel_bank) ? wdata
                                                                    : i_cur_status;

endmodule
`default_nettype wire

@@ tb/srt_result_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srt_result_checker
// Watches the instruction and result channels of the status register
// transfer unit. Every accepted instruction is run through a local model of
// the status word and the five saved words, and the predicted result is
// queued. Every accepted result is compared field by field with the oldest
// queued prediction. Mismatches are printed and counted for the testbench top.
// ----------------------------------------------------------------------------
module srt_result_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    srt_in_if         i_in_mon,
    srt_out_if        i_out_mon,
    output int        o_fail_count,
    output int        o_pending
);

    typedef enum logic [1:0] {
        TGT_CURRENT,
        TGT_BANK,
        TGT_NONE
    } t_target;

    logic [31:0]       model_status;
    logic [31:0]       model_bank [srt_pkg::BANK_DEPTH];
    srt_pkg::t_result  transfer_results [$];

    assign o_pending = transfer_results.size();

    function automatic logic cond_holds(srt_pkg::t_cond code, logic [31:0] st);
        logic n, z, c, v;
        n = st[31];
        z = st[30];
        c = st[29];
        v = st[28];
        case (code)
            srt_pkg::COND_EQ: return z;
            srt_pkg::COND_NE: return !z;
            srt_pkg::COND_CS: return c;
            srt_pkg::COND_CC: return !c;
            srt_pkg::COND_MI: return n;
            srt_pkg::COND_PL: return !n;
            srt_pkg::COND_VS: return v;
            srt_pkg::COND_VC: return !v;
            srt_pkg::COND_HI: return c && !z;
            srt_pkg::COND_LS: return !c || z;
            srt_pkg::COND_GE: return n == v;
            srt_pkg::COND_LT: return n != v;
            srt_pkg::COND_GT: return !z && (n == v);
            srt_pkg::COND_LE: return z || (n != v);
            srt_pkg::COND_AL: return 1'b1;
            default:          return 1'b0;
        endcase
    endfunction

    function automatic srt_pkg::t_result execute_transfer(srt_pkg::t_item it);
        srt_pkg::t_result   res;
        t_target            tgt;
        srt_pkg::t_bank_idx idx;
        logic [63:0]        wide;
        logic [31:0]        val;
        res = '0;
        tgt = TGT_CURRENT;
        idx = srt_pkg::BANK_FIQ;
        if (srt_pkg::t_cmd'(it.cmd) != srt_pkg::CMD_NONE
            && cond_holds(srt_pkg::t_cond'(it.instr[31:28]), model_status)) begin
            if (it.instr[22]) begin
                case (model_status[4:0])
                    srt_pkg::MODE_USR, srt_pkg::MODE_SYS: tgt = TGT_CURRENT;
                    srt_pkg::MODE_FIQ: begin tgt = TGT_BANK; idx = srt_pkg::BANK_FIQ; end
                    srt_pkg::MODE_IRQ: begin tgt = TGT_BANK; idx = srt_pkg::BANK_IRQ; end
                    srt_pkg::MODE_SVC: begin tgt = TGT_BANK; idx = srt_pkg::BANK_SVC; end
                    srt_pkg::MODE_ABT: begin tgt = TGT_BANK; idx = srt_pkg::BANK_ABT; end
                    srt_pkg::MODE_UND: begin tgt = TGT_BANK; idx = srt_pkg::BANK_UND; end
                    default:           tgt = TGT_NONE;
                endcase
            end
            if (tgt != TGT_NONE) begin
                res.executed = 1'b1;
                if (srt_pkg::t_cmd'(it.cmd) == srt_pkg::CMD_SR_TO_REG) begin
                    res.reg_write  = 1'b1;
                    res.dest_index = it.instr[15:12];
                    res.dest_value = (tgt == TGT_CURRENT) ? model_status : model_bank[idx];
                end else begin
                    wide = {24'd0, it.instr[7:0], 24'd0, it.instr[7:0]}
                           >> {it.instr[11:8], 1'b0};
                    val  = (srt_pkg::t_cmd'(it.cmd) == srt_pkg::CMD_REG_TO_SR)
                           ? it.source_value : wide[31:0];
                    if (tgt == TGT_CURRENT) begin
                        model_status = val;
                    end else begin
                        model_bank[idx] = val;
                    end
                end
            end
        end
        res.status_out = model_status;
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %08h want %08h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        srt_pkg::t_item   item;
        srt_pkg::t_result want;
        if (!i_rst_n) begin
            model_status = srt_pkg::STATUS_RESET;
            for (int i = 0; i < srt_pkg::BANK_DEPTH; i++) begin
                model_bank[i] = '0;
            end
            transfer_results.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (transfer_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result status_out %08h",
                                              i_out_mon.status_out));
                end else begin
                    want = transfer_results.pop_front();
                    check_field("executed", 32'(i_out_mon.executed), 32'(want.executed));
                    check_field("reg_write", 32'(i_out_mon.reg_write), 32'(want.reg_write));
                    check_field("dest_index", 32'(i_out_mon.dest_index),
                                32'(want.dest_index));
                    check_field("dest_value", i_out_mon.dest_value, want.dest_value);
                    check_field("status_out", i_out_mon.status_out, want.status_out);
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                item.cmd          = i_in_mon.cmd;
                item.instr        = i_in_mon.instr;
                item.source_value = i_in_mon.source_value;
                transfer_results.push_back(execute_transfer(item));
            end
        end
    end

endmodule
`default_nettype wire

@@ tb/tb_status_register_transfer_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_status_register_transfer_unit
// Drives status transfer instructions into the unit: a directed pass over
// banked and current words, rotated immediates, every condition code, the
// unused command and unknown modes, then constrained random traffic with
// random gaps on the instruction side and random stalls on the result side.
// Checking is done by srt_result_checker; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_status_register_transfer_unit;

    localparam int RANDOM_TRANSFERS = 900;
    localparam int QUIET_TAIL       = 150;

    logic i_clk;
    logic i_rst_n;
    logic quiet_tail;
    int   fail_count;
    int   pending;

    srt_in_if  in_ch ();
    srt_out_if out_ch ();

    status_register_transfer_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    srt_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 400000);
        $display("status: fail");
        $finish;
    end

    function automatic srt_pkg::t_item pack_transfer(srt_pkg::t_cmd cmd,
                                                     srt_pkg::t_cond cond,
                                                     logic bank_sel,
                                                     logic [3:0] rd, logic [3:0] rot,
                                                     logic [7:0] imm, logic [31:0] src);
        srt_pkg::t_item it;
        it.cmd          = cmd;
        it.instr        = '0;
        it.instr[31:28] = cond;
        it.instr[22]    = bank_sel;
        it.instr[15:12] = rd;
        it.instr[11:8]  = rot;
        it.instr[7:0]   = imm;
        it.source_value = src;
        return it;
    endfunction

    function automatic logic [4:0] pick_mode();
        case ($urandom_range(0, 6))
            0:       return srt_pkg::MODE_USR;
            1:       return srt_pkg::MODE_FIQ;
            2:       return srt_pkg::MODE_IRQ;
            3:       return srt_pkg::MODE_SVC;
            4:       return srt_pkg::MODE_ABT;
            5:       return srt_pkg::MODE_UND;
            default: return srt_pkg::MODE_SYS;
        endcase
    endfunction

    function automatic srt_pkg::t_item random_transfer();
        srt_pkg::t_item it;
        it.instr        = $urandom;
        it.source_value = $urandom;
        if ($urandom_range(0, 99) < 4) begin
            it.cmd = srt_pkg::CMD_NONE;
        end else begin
            it.cmd = 2'($urandom_range(0, 2));
        end
        if ($urandom_range(0, 9) < 4) begin
            it.instr[31:28] = srt_pkg::COND_AL;
        end
        if ($urandom_range(0, 9) < 8) begin
            it.source_value[4:0] = pick_mode();
        end
        if ($urandom_range(0, 1) == 0) begin
            it.instr[11:8] = '0;
            it.instr[4:0]  = pick_mode();
        end
        return it;
    endfunction

    task automatic send_transfer(srt_pkg::t_item it, bit allow_gap);
        if (allow_gap && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.cmd          <= it.cmd;
        in_ch.instr        <= it.instr;
        in_ch.source_value <= it.source_value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    initial begin
        out_ch.ready <= 1'b1;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                repeat ($urandom_range(0, 30)) @(posedge i_clk);
            end
        end
    end

    initial begin
        quiet_tail         <= 1'b0;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.cmd          <= srt_pkg::CMD_REG_TO_SR;
        in_ch.instr        <= '0;
        in_ch.source_value <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_transfer(pack_transfer(srt_pkg::CMD_SR_TO_REG, srt_pkg::COND_AL, 1'b0, 4'd15,
                                    4'd0, 8'h00, '0), 1);
        send_transfer(pack_transfer(srt_pkg::CMD_SR_TO_REG, srt_pkg::COND_AL, 1'b1, 4'd0,
                                    4'd0, 8'h00, '0), 1);
        send_transfer(pack_transfer(srt_pkg::CMD_REG_TO_SR, srt_pkg::COND_AL, 1'b1, 4'd0,
                                    4'd0, 8'h00, 32'hFFFF_FFFF), 1);
        send_transfer(pack_transfer(srt_pkg::CMD_SR_TO_REG, srt_pkg::COND_AL, 1'b1, 4'd1,
                                    4'd0, 8'h00, '0), 1);
        send_transfer(pack_transfer(srt_pkg::CMD_IMM_TO_SR, srt_pkg::COND_AL, 1'b1, 4'd0,
                                    4'd0, 8'hFF, '0), 1);
        send_transfer(pack_transfer(srt_pkg::CMD_SR_TO_REG, srt_pkg::COND_AL, 1'b1, 4'd2,
                                    4'd0, 8'h00, '0), 1);
        send_transfer(pack_transfer(srt_pkg::CMD_IMM_TO_SR, srt_pkg::COND_AL, 1'b1, 4'd0,
                                    4'd15, 8'h81, '0), 1);
        send_transfer(pack_transfer(srt_pkg::CMD_SR_TO_REG, srt_pkg::COND_AL, 1'b1, 4'd3,
                                    4'd0, 8'h00, '0), 1);
        send_transfer(pack_transfer(srt_pkg::CMD_NONE, srt_pkg::COND_AL, 1'b0, 4'd4,
                                    4'd0, 8'h00, 32'hFFFF_FFFF), 1);
        send_transfer(pack_transfer(srt_pkg::CMD_REG_TO_SR, srt_pkg::COND_NV, 1'b0, 4'd5,
                                    4'd0, 8'h00, '0), 1);
        send_transfer(pack_transfer(srt_pkg::CMD_REG_TO_SR, srt_pkg::COND_AL, 1'b0, 4'd0,
                                    4'd0, 8'h00, 32'h6000_0011), 1);
        for (int c = srt_pkg::COND_EQ; c <= srt_pkg::COND_LE; c++) begin
            send_transfer(pack_transfer(srt_pkg::CMD_SR_TO_REG, srt_pkg::t_cond'(c), c[0],
                                        4'(c), 4'd0, 8'h00, '0), 1);
        end
        send_transfer(pack_transfer(srt_pkg::CMD_REG_TO_SR, srt_pkg::COND_AL, 1'b0, 4'd0,
                                    4'd0, 8'h00, 32'h9000_0015), 1);
        send_transfer(pack_transfer(srt_pkg::CMD_IMM_TO_SR, srt_pkg::COND_AL, 1'b1, 4'd0,
                                    4'd0, 8'h5A, '0), 1);
        send_transfer(pack_transfer(srt_pkg::CMD_SR_TO_REG, srt_pkg::COND_AL, 1'b1, 4'd6,
                                    4'd0, 8'h00, '0), 1);
        send_transfer(pack_transfer(srt_pkg::CMD_IMM_TO_SR, srt_pkg::COND_AL, 1'b0, 4'd0,
                                    4'd0, 8'(srt_pkg::MODE_USR), '0), 1);
        send_transfer(pack_transfer(srt_pkg::CMD_SR_TO_REG, srt_pkg::COND_AL, 1'b1, 4'd7,
                                    4'd0, 8'h00, '0), 1);

        for (int n = 0; n < RANDOM_TRANSFERS; n++) begin
            if (n == RANDOM_TRANSFERS - QUIET_TAIL) begin
                quiet_tail <= 1'b1;
            end
            send_transfer(random_transfer(), n < RANDOM_TRANSFERS - QUIET_TAIL);
        end
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
design/srt_pkg.sv
design/srt_in_if.sv
design/srt_out_if.sv
design/srt_status_file.sv
design/srt_exec.sv
design/status_register_transfer_unit.sv
tb/srt_result_checker.sv
tb/tb_status_register_transfer_unit.sv
